FILE: hdl/rledc_pkg.sv
`default_nettype none

package rledc_pkg;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int unsigned NUM_DIGITS = 5;
    localparam logic [2:0]  LAST_PIDX  = 3'd4;
    localparam logic [7:0]  ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic [7:0]  run_byte;
        logic [15:0] run_len;
        logic        sat;
        logic        last;
        logic        eos;
    } t_cmd;

    localparam logic [16:0] DIG_MULT [NUM_DIGITS][10] = '{
        '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
          17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
        '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
          17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
        '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
          17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
        '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
          17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
        '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
          17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
    };

endpackage

`default_nettype wire

FILE: hdl/rledc_cmdq.sv
`default_nettype none

module rledc_cmdq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire rledc_pkg::t_cmd i_wr_cmd,
    output logic                 o_full,
    input  wire logic            i_rd,
    output logic                 o_valid,
    output rledc_pkg::t_cmd      o_head
);

    rledc_pkg::t_cmd                  r_mem [rledc_pkg::Q_DEPTH];
    logic [rledc_pkg::Q_AW-1:0]       r_wr_ptr;
    logic [rledc_pkg::Q_AW-1:0]       r_rd_ptr;
    logic [rledc_pkg::Q_CW-1:0]       r_count;
    logic                             w_do_wr;
    logic                             w_do_rd;

    assign o_full  = (r_count == rledc_pkg::Q_CW'(rledc_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_wr, w_do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rledc_front.sv
`default_nettype none

module rledc_front #(
    parameter int unsigned MAX_RUN = 65535
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_stream_end,
    input  wire logic            i_q_full,
    output logic                 o_q_wr,
    output rledc_pkg::t_cmd      o_q_cmd
);

    localparam logic [15:0] MaxLen = 16'(MAX_RUN);

    logic [7:0]      r_held;
    logic [15:0]     r_len;
    logic            r_active;
    logic            r_clip;
    logic            r_pend_v;
    rledc_pkg::t_cmd r_pend;

    logic            w_accept;
    logic            w_ext;
    logic            w_close;
    logic [15:0]     n_len;
    logic            n_clip;
    logic [7:0]      n_held;
    rledc_pkg::t_cmd w_old_run;
    rledc_pkg::t_cmd w_end_run;

    assign o_full   = r_pend_v || i_q_full;
    assign w_accept = i_push && !o_full;
    assign w_ext    = r_active && (i_in_byte == r_held);
    assign w_close  = r_active && !w_ext;

    always_comb begin
        if (w_ext) begin
            n_held = r_held;
            if (r_len >= MaxLen) begin
                n_len  = MaxLen;
                n_clip = 1'b1;
            end else begin
                n_len  = r_len + 16'd1;
                n_clip = r_clip;
            end
        end else begin
            n_held = i_in_byte;
            n_len  = 16'd1;
            n_clip = 1'b0;
        end
    end

    always_comb begin
        w_old_run.run_byte = r_held;
        w_old_run.run_len  = r_len;
        w_old_run.sat      = r_clip;
        w_old_run.last     = !i_stream_end;
        w_old_run.eos      = 1'b0;

        w_end_run.run_byte = n_held;
        w_end_run.run_len  = n_len;
        w_end_run.sat      = n_clip;
        w_end_run.last     = 1'b1;
        w_end_run.eos      = 1'b1;
    end

    always_comb begin
        if (r_pend_v) begin
            o_q_wr  = !i_q_full;
            o_q_cmd = r_pend;
        end else begin
            o_q_wr  = w_accept && (w_close || i_stream_end);
            o_q_cmd = w_close ? w_old_run : w_end_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_close && i_stream_end) begin
            r_pend <= w_end_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_len    <= '0;
            r_active <= 1'b0;
            r_clip   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (r_pend_v && !i_q_full) begin
                r_pend_v <= 1'b0;
            end
            if (w_accept) begin
                r_held <= n_held;
                if (i_stream_end) begin
                    r_len    <= '0;
                    r_clip   <= 1'b0;
                    r_active <= 1'b0;
                end else begin
                    r_len    <= n_len;
                    r_clip   <= n_clip;
                    r_active <= 1'b1;
                end
                if (w_close && i_stream_end) begin
                    r_pend_v <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rledc_back.sv
`default_nettype none

module rledc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire rledc_pkg::t_cmd i_q_head,
    output logic                 o_q_rd,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output logic [7:0]           o_out_byte,
    output logic                 o_item_done,
    output logic                 o_end_of_stream,
    output logic                 o_run_saturated
);

    logic        r_busy;
    logic        r_digits;
    logic        r_multi;
    logic [7:0]  r_byte;
    logic [15:0] r_rem;
    logic [2:0]  r_pidx;
    logic        r_sat;
    logic        r_last;
    logic        r_eos;

    logic        r_out_v;
    logic [7:0]  r_out_byte;
    logic        r_out_done;
    logic        r_out_eos;
    logic        r_out_sat;

    logic        w_go;
    logic [3:0]  w_dig;
    logic [16:0] w_sub;
    logic [2:0]  w_start;
    logic        w_done;
    logic [7:0]  n_out_byte;

    assign o_empty         = !r_out_v;
    assign o_out_byte      = r_out_byte;
    assign o_item_done     = r_out_done;
    assign o_end_of_stream = r_out_eos;
    assign o_run_saturated = r_out_sat;

    assign w_go   = r_busy && (!r_out_v || i_pop);
    assign o_q_rd = !r_busy && i_q_valid;

    always_comb begin
        w_dig = 4'd0;
        for (int d = 1; d < 10; d++) begin
            if ({1'b0, r_rem} >= rledc_pkg::DIG_MULT[r_pidx][4'(d)]) begin
                w_dig = 4'(d);
            end
        end
        w_sub = rledc_pkg::DIG_MULT[r_pidx][w_dig];
    end

    always_comb begin
        if (i_q_head.run_len >= 16'd10000) begin
            w_start = 3'd0;
        end else if (i_q_head.run_len >= 16'd1000) begin
            w_start = 3'd1;
        end else if (i_q_head.run_len >= 16'd100) begin
            w_start = 3'd2;
        end else if (i_q_head.run_len >= 16'd10) begin
            w_start = 3'd3;
        end else begin
            w_start = rledc_pkg::LAST_PIDX;
        end
    end

    always_comb begin
        if (r_digits) begin
            w_done     = (r_pidx == rledc_pkg::LAST_PIDX);
            n_out_byte = rledc_pkg::ASCII_ZERO + {4'd0, w_dig};
        end else begin
            w_done     = !r_multi;
            n_out_byte = r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_byte  <= i_q_head.run_byte;
            r_rem   <= i_q_head.run_len;
            r_multi <= (i_q_head.run_len > 16'd1);
            r_pidx  <= w_start;
            r_sat   <= i_q_head.sat;
            r_last  <= i_q_head.last;
            r_eos   <= i_q_head.eos;
        end else if (w_go && r_digits) begin
            r_rem  <= 16'({1'b0, r_rem} - w_sub);
            r_pidx <= r_pidx + 3'd1;
        end
        if (w_go) begin
            r_out_byte <= n_out_byte;
            r_out_done <= r_last && w_done;
            r_out_eos  <= r_eos && w_done;
            r_out_sat  <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_digits <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (o_q_rd) begin
                r_busy   <= 1'b1;
                r_digits <= 1'b0;
            end else if (w_go) begin
                if (w_done) begin
                    r_busy <= 1'b0;
                end
                r_digits <= 1'b1;
            end
            if (w_go) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/run_length_encoder_decimal_counts_core.sv
// Run-length encoder over a byte stream with decimal run counts.
// Input channel: an input beat is taken when push is high and full is low; it
// carries one byte and a mark that ends the stream. Result channel: while empty
// is low the oldest result beat is on the output ports, and pop takes it.
// Each finished run leaves as its byte, followed by the run length as ASCII
// decimal digits when the length exceeds one. item_done marks the last result
// beat caused by an input beat, end_of_stream marks the last beat of a stream.
// The back end takes a run from the command queue, then sends its byte and
// then its digits, one per result beat; it takes the next run only after the
// last beat of the current one. The first result of a run passes from the
// input beat that closes it through the command queue, the back-end run
// registers and the output register. A byte change with an end mark closes
// two runs and holds off the input until the second run enters the queue.
// Reset clears the held run, the command queue and the output register.
// When the receiver stalls, the output register holds its beat, the back end
// waits, the four-entry command queue fills and full rises to stall the sender.
`default_nettype none

module run_length_encoder_decimal_counts_core #(
    parameter int unsigned MAX_RUN = 65535
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_stream_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_item_done,
    output logic            o_end_of_stream,
    output logic            o_run_saturated
);

    logic            w_q_full;
    logic            w_q_wr;
    rledc_pkg::t_cmd w_q_wr_cmd;
    logic            w_q_rd;
    logic            w_q_valid;
    rledc_pkg::t_cmd w_q_head;

    rledc_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_in_byte    (i_in_byte),
        .i_stream_end (i_stream_end),
        .i_q_full     (w_q_full),
        .o_q_wr       (w_q_wr),
        .o_q_cmd      (w_q_wr_cmd)
    );

    rledc_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_q_wr),
        .i_wr_cmd (w_q_wr_cmd),
        .o_full   (w_q_full),
        .i_rd     (w_q_rd),
        .o_valid  (w_q_valid),
        .o_head   (w_q_head)
    );

    rledc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_head        (w_q_head),
        .o_q_rd          (w_q_rd),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_out_byte      (o_out_byte),
        .o_item_done     (o_item_done),
        .o_end_of_stream (o_end_of_stream),
        .o_run_saturated (o_run_saturated)
    );

endmodule

`default_nettype wire

FILE: dv/run_length_encoder_decimal_counts_core_tb.sv
`timescale 1ns / 100ps

module run_length_encoder_decimal_counts_core_tb;

    localparam int unsigned RUN_CAP      = 65535;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;
    localparam int unsigned TAIL_CYCLES  = 24;
    localparam int unsigned RX_LONG_HOLD = 300;
    localparam int unsigned RANDOM_ITEMS = 230;
    localparam int unsigned RANDOM_CODES = 60;

    typedef struct packed {
        logic [7:0] code;
        logic       done;
        logic       eos;
        logic       sat;
    } t_enc_beat;

    typedef struct packed {
        logic [7:0]  rbyte;
        logic [16:0] reps;
        logic        rend;
        logic [2:0]  tlen;
        logic [47:0] tcodes;
        logic        tsat;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       i_stream_end;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_item_done;
    logic       o_end_of_stream;
    logic       o_run_saturated;

    t_enc_beat encoded_q [$];
    t_enc_beat step_q [$];
    t_stim_row dir_rows [$];

    logic [7:0]  run_byte;
    logic [15:0] run_len;
    logic        run_on;
    logic        run_sat;

    int unsigned errors;
    int unsigned cycle_count;
    int unsigned codes_sent;
    bit          tx_steady;
    bit          rx_steady;
    bit          rx_hold_req;
    t_enc_beat   want;

    run_length_encoder_decimal_counts_core #(
        .MAX_RUN(RUN_CAP)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_stream_end   (i_stream_end),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_item_done    (o_item_done),
        .o_end_of_stream(o_end_of_stream),
        .o_run_saturated(o_run_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_gap(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 45) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_stim_row stim_row(input logic [7:0] rbyte, input int unsigned reps,
                                           input bit rend, input int unsigned tlen,
                                           input logic [47:0] tcodes, input bit tsat);
        t_stim_row row;
        row.rbyte  = rbyte;
        row.reps   = reps[16:0];
        row.rend   = rend;
        row.tlen   = tlen[2:0];
        row.tcodes = tcodes;
        row.tsat   = tsat;
        return row;
    endfunction

    task automatic note_code(input logic [7:0] code);
        t_enc_beat beat;
        beat.code = code;
        beat.done = 1'b0;
        beat.eos  = 1'b0;
        beat.sat  = run_sat;
        step_q.push_back(beat);
    endtask

    task automatic flush_run();
        int unsigned n;
        int          nd;
        int          i;
        logic [7:0]  digs [5];
        n  = 32'(run_len);
        nd = 0;
        note_code(run_byte);
        if (n > 1) begin
            while (n > 0) begin
                digs[nd] = rledc_pkg::ASCII_ZERO + 8'(n % 10);
                n        = n / 10;
                nd++;
            end
            for (i = nd - 1; i >= 0; i--) begin
                note_code(digs[i]);
            end
        end
        run_on  = 1'b0;
        run_len = '0;
        run_sat = 1'b0;
    endtask

    task automatic encode_byte(input logic [7:0] b_in, input logic last_in);
        t_enc_beat tail;
        step_q.delete();
        if (run_on && b_in == run_byte) begin
            if (32'(run_len) >= RUN_CAP) begin
                run_len = RUN_CAP[15:0];
                run_sat = 1'b1;
            end else begin
                run_len = run_len + 16'd1;
            end
        end else begin
            if (run_on) begin
                flush_run();
            end
            run_byte = b_in;
            run_len  = 16'd1;
            run_sat  = 1'b0;
            run_on   = 1'b1;
        end
        if (last_in) begin
            flush_run();
            tail     = step_q.pop_back();
            tail.eos = 1'b1;
            step_q.push_back(tail);
        end
        if (step_q.size() > 0) begin
            tail      = step_q.pop_back();
            tail.done = 1'b1;
            step_q.push_back(tail);
        end
    endtask

    task automatic drive_beat(input logic [7:0] b_in, input logic last_in, input bit quiet,
                              input int unsigned tlen, input logic [47:0] tcodes,
                              input bit tsat);
        int unsigned gap;
        int unsigned i;
        t_enc_beat   beat;
        gap = quiet ? 0 : idle_gap(tx_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_in_byte    <= b_in;
        i_stream_end <= last_in;
        do @(posedge i_clk); while (full);
        encode_byte(b_in, last_in);
        if (tlen != 0) begin
            for (i = 0; i < tlen; i++) begin
                beat.code = tcodes[8 * (tlen - 1 - i) +: 8];
                beat.done = (i == tlen - 1);
                beat.eos  = (i == tlen - 1);
                beat.sat  = tsat;
                encoded_q.push_back(beat);
            end
        end else begin
            foreach (step_q[i]) begin
                encoded_q.push_back(step_q[i]);
            end
        end
        codes_sent += step_q.size();
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (encoded_q.size() != 0);
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (encoded_q.size() == 0) begin
                $error("unexpected result beat: out_byte %02h", o_out_byte);
                errors++;
            end else begin
                want = encoded_q.pop_front();
                if (o_out_byte !== want.code) begin
                    $error("out_byte: expected %02h, got %02h", want.code, o_out_byte);
                    errors++;
                end
                if (o_item_done !== want.done) begin
                    $error("item_done: expected %0b, got %0b", want.done, o_item_done);
                    errors++;
                end
                if (o_end_of_stream !== want.eos) begin
                    $error("end_of_stream: expected %0b, got %0b", want.eos,
                           o_end_of_stream);
                    errors++;
                end
                if (o_run_saturated !== want.sat) begin
                    $error("run_saturated: expected %0b, got %0b", want.sat,
                           o_run_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        int unsigned beats;
        int unsigned gap;
        beats     = 0;
        rx_steady = 1'b0;
        pop      <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 32 == 0) begin
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if (rx_hold_req) begin
                gap         = RX_LONG_HOLD;
                rx_hold_req = 1'b0;
            end else begin
                gap = idle_gap(rx_steady);
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            beats++;
        end
    end

    initial begin
        int unsigned sent;
        int unsigned stream_idx;
        int unsigned nruns;
        int unsigned rlen;
        int unsigned r;
        int unsigned k;
        logic [7:0]  b_pick;
        logic        last_in;
        t_stim_row   row;

        errors       = 0;
        codes_sent   = 0;
        tx_steady    = 1'b0;
        rx_hold_req  = 1'b0;
        run_byte     = '0;
        run_len      = '0;
        run_on       = 1'b0;
        run_sat      = 1'b0;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_in_byte    <= '0;
        i_stream_end <= 1'b0;

        dir_rows.push_back(stim_row(8'h00, 1, 1'b1, 1, 48'h00, 1'b0));
        dir_rows.push_back(stim_row(8'hFF, 2, 1'b1, 2, 48'({8'hFF, "2"}), 1'b0));
        dir_rows.push_back(stim_row("A", 9, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row("A", 1, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row("B", 1, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row("C", 1, 1'b1, 0, '0, 1'b0));
        dir_rows.push_back(stim_row("U", 100, 1'b1, 4, 48'("U100"), 1'b0));
        dir_rows.push_back(stim_row(8'h7F, 1, 1'b1, 0, '0, 1'b0));
        dir_rows.push_back(stim_row(8'h01, 3, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row(8'h02, 1, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row(8'h01, 2, 1'b1, 0, '0, 1'b0));
        dir_rows.push_back(stim_row("0", 5, 1'b1, 2, 48'("05"), 1'b0));
        dir_rows.push_back(stim_row(8'h00, 1, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row(8'h00, 1, 1'b1, 0, '0, 1'b0));
        dir_rows.push_back(stim_row(8'h5A, 1, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row(8'h5B, 1, 1'b0, 0, '0, 1'b0));
        dir_rows.push_back(stim_row(8'h5A, 1, 1'b1, 0, '0, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Long runs go through without sender gaps after their first few beats.
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            for (k = 0; k < row.reps; k++) begin
                last_in = row.rend && (k == row.reps - 1);
                drive_beat(row.rbyte, last_in, (row.reps >= 100) && (k >= 4),
                           (k == row.reps - 1) ? row.tlen : 0, row.tcodes, row.tsat);
            end
        end
        wait_drained();

        sent       = 0;
        stream_idx = 0;
        codes_sent = 0;
        while (sent < RANDOM_ITEMS || codes_sent < RANDOM_CODES) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if (stream_idx == 1 || stream_idx == 6) begin
                rx_hold_req = 1'b1;
                tx_steady   = 1'b1;
            end
            nruns = $urandom_range(1, 8);
            for (int unsigned j = 0; j < nruns; j++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    rlen = 1;
                end else if (r < 90) begin
                    rlen = $urandom_range(2, 9);
                end else if (r < 98) begin
                    rlen = $urandom_range(10, 99);
                end else begin
                    rlen = $urandom_range(100, 130);
                end
                if ($urandom_range(0, 1) == 0) begin
                    b_pick = $urandom_range(0, 1) ? "a" : "b";
                end else begin
                    b_pick = 8'($urandom_range(0, 255));
                end
                for (k = 0; k < rlen; k++) begin
                    last_in = (j == nruns - 1) && (k == rlen - 1);
                    if (!last_in && $urandom_range(0, 39) == 0) begin
                        last_in = 1'b1;
                    end
                    drive_beat(b_pick, last_in, 1'b0, 0, '0, 1'b0);
                    sent++;
                end
            end
            stream_idx++;
            if (stream_idx % 5 == 3) begin
                wait_drained();
            end
        end
        drive_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, 0, '0, 1'b0);

        push <= 1'b0;
        while (encoded_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
